[hdl/mpfp_pkg.sv]
// ----------------------------------------------------------------------------
// mpfp_pkg
// Shared types, codes and helpers for the MQTT packet field parser.
// ----------------------------------------------------------------------------
`default_nettype none
package mpfp_pkg;

  localparam int MAX_SUB_ENTRIES_DEF = 10;
  localparam int FIFO_DEPTH_DEF      = 4;
  localparam logic [16:0] MAX_STRING_LEN_RST = 17'd256;

  // record kinds
  localparam logic [3:0] K_HEADER    = 4'd0;
  localparam logic [3:0] K_REMLEN    = 4'd1;
  localparam logic [3:0] K_VERSION   = 4'd2;
  localparam logic [3:0] K_CONNFLAGS = 4'd3;
  localparam logic [3:0] K_KEEPALIVE = 4'd4;
  localparam logic [3:0] K_PACKETID  = 4'd5;
  localparam logic [3:0] K_STRLEN    = 4'd6;
  localparam logic [3:0] K_STRBYTE   = 4'd7;
  localparam logic [3:0] K_SUBQOS    = 4'd8;
  localparam logic [3:0] K_PAYLOAD   = 4'd9;
  localparam logic [3:0] K_VERDICT   = 4'd10;

  // verdicts
  localparam logic [2:0] V_OK        = 3'd0;
  localparam logic [2:0] V_SHORT     = 3'd1;
  localparam logic [2:0] V_BADLEN    = 3'd2;
  localparam logic [2:0] V_TRUNC     = 3'd3;
  localparam logic [2:0] V_UNKNOWN   = 3'd4;
  localparam logic [2:0] V_MALFORMED = 3'd5;

  // string slots
  localparam logic [2:0] S_PROTONAME = 3'd0;
  localparam logic [2:0] S_CLIENTID  = 3'd1;
  localparam logic [2:0] S_WILLTOPIC = 3'd2;
  localparam logic [2:0] S_WILLMSG   = 3'd3;
  localparam logic [2:0] S_USER      = 3'd4;
  localparam logic [2:0] S_PASSWORD  = 3'd5;
  localparam logic [2:0] S_PUBTOPIC  = 3'd6;
  localparam logic [2:0] S_SUBTOPIC  = 3'd7;

  // control packet types
  localparam logic [3:0] T_CONNECT   = 4'd1;
  localparam logic [3:0] T_CONNACK   = 4'd2;
  localparam logic [3:0] T_PUBLISH   = 4'd3;
  localparam logic [3:0] T_SUBSCRIBE = 4'd8;
  localparam logic [3:0] T_UNSUBACK  = 4'd10;
  localparam logic [3:0] T_PINGREQ   = 4'd12;
  localparam logic [3:0] T_PINGRESP  = 4'd13;
  localparam logic [3:0] T_DISCONN   = 4'd14;

  typedef struct packed {
    logic [3:0]  kind;
    logic [27:0] value;
    logic [2:0]  string_slot;
    logic [3:0]  entry_index;
    logic [3:0]  ctrl_type;
    logic        dup_flag;
    logic [1:0]  qos_level;
    logic        retain_flag;
    logic [2:0]  verdict;
    logic        packet_last;
  } rec_t;

  // up to two records produced by one byte
  typedef struct packed {
    logic [1:0] cnt;
    rec_t       rec0;
    rec_t       rec1;
  } pair_t;

  function automatic rec_t make_rec(input logic [3:0] kind, input logic [27:0] value,
                                    input logic [2:0] slot, input logic [3:0] entry,
                                    input logic [2:0] verdict, input logic [7:0] hdr);
    rec_t r;
    r.kind        = kind;
    r.value       = value;
    r.string_slot = slot;
    r.entry_index = entry;
    r.ctrl_type   = hdr[7:4];
    r.dup_flag    = hdr[3];
    r.qos_level   = hdr[2:1];
    r.retain_flag = hdr[0];
    r.verdict     = verdict;
    r.packet_last = (kind == K_VERDICT);
    return r;
  endfunction

endpackage
`default_nettype wire

[hdl/mpfp_parser.sv]
// ----------------------------------------------------------------------------
// mpfp_parser
// Front end: per-byte MQTT state machine, produces up to two records a byte.
// ----------------------------------------------------------------------------
`default_nettype none
module mpfp_parser #(
  parameter int MAX_SUB_ENTRIES = mpfp_pkg::MAX_SUB_ENTRIES_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_write,
  input  wire logic [16:0]   cfg_data,
  input  wire logic          accept,
  input  wire logic [7:0]    data_byte,
  input  wire logic          segment_end,
  output mpfp_pkg::pair_t    pair
);
  import mpfp_pkg::*;

  localparam logic [3:0] PH_HDR      = 4'd0;
  localparam logic [3:0] PH_LEN      = 4'd1;
  localparam logic [3:0] PH_CLOSED   = 4'd2;
  localparam logic [3:0] PH_SKIP     = 4'd3;
  localparam logic [3:0] PH_STR_HI   = 4'd4;
  localparam logic [3:0] PH_STR_LO   = 4'd5;
  localparam logic [3:0] PH_STR_BODY = 4'd6;
  localparam logic [3:0] PH_VERSION  = 4'd7;
  localparam logic [3:0] PH_FLAGS    = 4'd8;
  localparam logic [3:0] PH_KA_HI    = 4'd9;
  localparam logic [3:0] PH_KA_LO    = 4'd10;
  localparam logic [3:0] PH_PID_HI   = 4'd11;
  localparam logic [3:0] PH_PID_LO   = 4'd12;
  localparam logic [3:0] PH_PAYLOAD  = 4'd13;
  localparam logic [3:0] PH_SUBQOS   = 4'd14;

  localparam logic [3:0] MAX_ENT = 4'(MAX_SUB_ENTRIES);

  typedef struct packed {
    logic [3:0] phase;
    logic [2:0] slot;
    logic [2:0] pend;
  } nx_t;

  logic [16:0] max_string_len;
  logic [3:0]  phase, phase_next;
  logic [7:0]  header_bits, header_bits_next;
  logic [27:0] remaining_count, remaining_count_next;
  logic [2:0]  length_byte_count, length_byte_count_next;
  logic [7:0]  connect_flag_bits, connect_flag_bits_next;
  logic [15:0] string_count, string_count_next;
  logic [2:0]  current_slot, current_slot_next;
  logic [3:0]  entry_count, entry_count_next;
  logic [7:0]  high_byte_hold, high_byte_hold_next;
  logic [2:0]  pending_verdict, pending_verdict_next;

  function automatic nx_t go_str(input logic [2:0] s, input nx_t cur);
    nx_t r;
    r = cur;
    r.phase = PH_STR_HI;
    r.slot  = s;
    return r;
  endfunction

  function automatic nx_t go_skip(input logic [2:0] v, input nx_t cur);
    nx_t r;
    r = cur;
    r.phase = PH_SKIP;
    r.pend  = v;
    return r;
  endfunction

  function automatic nx_t after_pw(input logic [7:0] fl, input nx_t cur);
    return fl[6] ? go_str(S_PASSWORD, cur) : go_skip(V_OK, cur);
  endfunction

  function automatic nx_t after_will(input logic [7:0] fl, input nx_t cur);
    return fl[7] ? go_str(S_USER, cur) : after_pw(fl, cur);
  endfunction

  function automatic nx_t begin_entry(input logic [3:0] cnt, input nx_t cur);
    return (cnt < MAX_ENT) ? go_str(S_SUBTOPIC, cur) : go_skip(V_OK, cur);
  endfunction

  function automatic nx_t after_string(input logic [7:0] fl, input logic [1:0] qos,
                                       input nx_t cur);
    nx_t r;
    r = cur;
    case (cur.slot)
      S_PROTONAME: r.phase = PH_VERSION;
      S_CLIENTID:  r = fl[2] ? go_str(S_WILLTOPIC, cur) : after_will(fl, cur);
      S_WILLTOPIC: r = go_str(S_WILLMSG, cur);
      S_WILLMSG:   r = after_will(fl, cur);
      S_USER:      r = after_pw(fl, cur);
      S_PASSWORD:  r = go_skip(V_OK, cur);
      S_PUBTOPIC:  r.phase = (qos != 2'd0) ? PH_PID_HI : PH_PAYLOAD;
      default:     r.phase = PH_SUBQOS;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] end_verdict(input nx_t cur);
    logic [2:0] v;
    case (cur.phase)
      PH_STR_HI, PH_STR_LO, PH_STR_BODY:
        v = (cur.slot == S_SUBTOPIC) ? V_OK : V_MALFORMED;
      PH_VERSION, PH_FLAGS, PH_KA_HI, PH_KA_LO, PH_PID_HI, PH_PID_LO:
        v = V_MALFORMED;
      PH_PAYLOAD, PH_SUBQOS:
        v = V_OK;
      default:
        v = cur.pend;
    endcase
    return v;
  endfunction

  logic        f_valid;
  rec_t        f_rec;
  logic        c_valid;
  logic [2:0]  c_verdict;
  logic [7:0]  hb;
  nx_t         nx;
  logic [27:0] rc;
  logic [27:0] shifted;
  logic [15:0] len;
  logic [3:0]  ent;
  rec_t        c_rec;

  always_comb begin
    phase_next             = phase;
    header_bits_next       = header_bits;
    remaining_count_next   = remaining_count;
    length_byte_count_next = length_byte_count;
    connect_flag_bits_next = connect_flag_bits;
    string_count_next      = string_count;
    entry_count_next       = entry_count;
    high_byte_hold_next    = high_byte_hold;
    nx.phase = phase;
    nx.slot  = current_slot;
    nx.pend  = pending_verdict;
    f_valid   = 1'b0;
    c_valid   = 1'b0;
    c_verdict = V_OK;
    hb        = (phase == PH_HDR) ? data_byte : header_bits;
    f_rec     = make_rec(K_HEADER, 28'(data_byte), 3'd0, 4'd0, V_OK, hb);
    len       = {high_byte_hold, data_byte};
    ent       = (current_slot == S_SUBTOPIC) ? entry_count : 4'd0;
    rc        = remaining_count;
    case (length_byte_count[1:0])
      2'd0:    shifted = 28'(data_byte[6:0]);
      2'd1:    shifted = {14'd0, data_byte[6:0], 7'd0};
      2'd2:    shifted = {7'd0, data_byte[6:0], 14'd0};
      default: shifted = {data_byte[6:0], 21'd0};
    endcase

    if (phase == PH_HDR) begin
      header_bits_next = data_byte;
      f_valid = 1'b1;
      if (segment_end) begin
        c_valid = 1'b1;
        c_verdict = V_SHORT;
      end else begin
        nx.phase = PH_LEN;
        remaining_count_next = 28'd0;
        length_byte_count_next = 3'd0;
      end
    end else if (phase == PH_LEN) begin
      rc = remaining_count | shifted;
      remaining_count_next = rc;
      length_byte_count_next = length_byte_count + 3'd1;
      if (data_byte[7]) begin
        if (length_byte_count_next >= 3'd4 || segment_end) begin
          c_valid = 1'b1;
          c_verdict = V_BADLEN;
        end
      end else begin
        f_valid = 1'b1;
        f_rec = make_rec(K_REMLEN, rc, 3'd0, 4'd0, V_OK, hb);
        case (header_bits[7:4])
          T_CONNECT:   nx = go_str(S_PROTONAME, nx);
          T_PUBLISH:   nx = go_str(S_PUBTOPIC, nx);
          T_SUBSCRIBE: begin
            entry_count_next = 4'd0;
            nx.phase = PH_PID_HI;
          end
          T_CONNACK, T_UNSUBACK, T_PINGREQ, T_PINGRESP, T_DISCONN:
            nx = go_skip(V_OK, nx);
          default: nx = go_skip(V_UNKNOWN, nx);
        endcase
        if (rc == 28'd0) begin
          c_valid = 1'b1;
          c_verdict = end_verdict(nx);
        end else if (segment_end) begin
          c_valid = 1'b1;
          c_verdict = V_TRUNC;
        end
      end
    end else if (phase != PH_CLOSED) begin
      rc = remaining_count - 28'd1;
      remaining_count_next = rc;
      case (phase)
        PH_STR_HI: begin
          high_byte_hold_next = data_byte;
          nx.phase = PH_STR_LO;
        end
        PH_STR_LO: begin
          f_valid = 1'b1;
          f_rec = make_rec(K_STRLEN, 28'(len), current_slot, ent, V_OK, hb);
          if (17'(len) >= max_string_len || 28'(len) > rc) begin
            nx = go_skip((current_slot == S_SUBTOPIC) ? V_OK : V_MALFORMED, nx);
          end else if (len == 16'd0) begin
            nx = after_string(connect_flag_bits, header_bits[2:1], nx);
          end else begin
            string_count_next = len;
            nx.phase = PH_STR_BODY;
          end
        end
        PH_STR_BODY: begin
          f_valid = 1'b1;
          f_rec = make_rec(K_STRBYTE, 28'(data_byte), current_slot, ent, V_OK, hb);
          string_count_next = string_count - 16'd1;
          if (string_count_next == 16'd0)
            nx = after_string(connect_flag_bits, header_bits[2:1], nx);
        end
        PH_VERSION: begin
          f_valid = 1'b1;
          f_rec = make_rec(K_VERSION, 28'(data_byte), 3'd0, 4'd0, V_OK, hb);
          nx.phase = PH_FLAGS;
        end
        PH_FLAGS: begin
          connect_flag_bits_next = data_byte;
          f_valid = 1'b1;
          f_rec = make_rec(K_CONNFLAGS, 28'(data_byte), 3'd0, 4'd0, V_OK, hb);
          nx.phase = PH_KA_HI;
        end
        PH_KA_HI, PH_PID_HI: begin
          high_byte_hold_next = data_byte;
          nx.phase = phase + 4'd1;
        end
        PH_KA_LO: begin
          f_valid = 1'b1;
          f_rec = make_rec(K_KEEPALIVE, 28'(len), 3'd0, 4'd0, V_OK, hb);
          nx = go_str(S_CLIENTID, nx);
        end
        PH_PID_LO: begin
          f_valid = 1'b1;
          f_rec = make_rec(K_PACKETID, 28'(len), 3'd0, 4'd0, V_OK, hb);
          if (header_bits[7:4] == T_PUBLISH)
            nx.phase = PH_PAYLOAD;
          else
            nx = begin_entry(entry_count, nx);
        end
        PH_PAYLOAD: begin
          f_valid = 1'b1;
          f_rec = make_rec(K_PAYLOAD, 28'(data_byte), 3'd0, 4'd0, V_OK, hb);
        end
        PH_SUBQOS: begin
          f_valid = 1'b1;
          f_rec = make_rec(K_SUBQOS, 28'(data_byte), 3'd0, entry_count, V_OK, hb);
          entry_count_next = entry_count + 4'd1;
          nx = begin_entry(entry_count_next, nx);
        end
        default: ;
      endcase
      if (rc == 28'd0) begin
        c_valid = 1'b1;
        c_verdict = end_verdict(nx);
      end else if (segment_end) begin
        c_valid = 1'b1;
        c_verdict = V_TRUNC;
      end
    end

    if (c_valid)
      nx.phase = PH_CLOSED;
    phase_next           = nx.phase;
    current_slot_next    = nx.slot;
    pending_verdict_next = nx.pend;

    c_rec = make_rec(K_VERDICT, 28'd0, 3'd0, 4'd0, c_verdict, hb);
    pair.cnt  = 2'(f_valid) + 2'(c_valid);
    pair.rec0 = f_valid ? f_rec : c_rec;
    pair.rec1 = c_rec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_string_len <= MAX_STRING_LEN_RST;
    end else if (cfg_write) begin
      max_string_len <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && segment_end)) begin
      phase             <= PH_HDR;
      header_bits       <= 8'd0;
      remaining_count   <= 28'd0;
      length_byte_count <= 3'd0;
      connect_flag_bits <= 8'd0;
      string_count      <= 16'd0;
      current_slot      <= 3'd0;
      entry_count       <= 4'd0;
      high_byte_hold    <= 8'd0;
      pending_verdict   <= V_OK;
    end else if (accept) begin
      phase             <= phase_next;
      header_bits       <= header_bits_next;
      remaining_count   <= remaining_count_next;
      length_byte_count <= length_byte_count_next;
      connect_flag_bits <= connect_flag_bits_next;
      string_count      <= string_count_next;
      current_slot      <= current_slot_next;
      entry_count       <= entry_count_next;
      high_byte_hold    <= high_byte_hold_next;
      pending_verdict   <= pending_verdict_next;
    end
  end

endmodule
`default_nettype wire

[hdl/mpfp_queue.sv]
// ----------------------------------------------------------------------------
// mpfp_queue
// Small FIFO of record pairs between the parser and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none
module mpfp_queue #(
  parameter int DEPTH = mpfp_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire mpfp_pkg::pair_t wdata,
  output logic                 full,
  output logic                 not_empty,
  input  wire logic            pop,
  output mpfp_pkg::pair_t      rdata
);
  import mpfp_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  pair_t          mem [DEPTH];
  logic [AW-1:0]  wr_ptr, rd_ptr;
  logic [AW:0]    count;
  logic           do_push, do_pop;

  assign full      = (count == (AW+1)'(DEPTH));
  assign not_empty = (count != '0);
  assign rdata     = mem[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push)
      mem[wr_ptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push)
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      if (do_pop)
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      count <= count + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end

endmodule
`default_nettype wire

[hdl/mpfp_emitter.sv]
// ----------------------------------------------------------------------------
// mpfp_emitter
// Back end: holds one record pair and sends its records one per transaction.
// ----------------------------------------------------------------------------
`default_nettype none
module mpfp_emitter (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            q_not_empty,
  input  wire mpfp_pkg::pair_t q_data,
  output logic                 q_pop,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output mpfp_pkg::rec_t       out_rec
);
  import mpfp_pkg::*;

  logic  held;
  logic  sel;
  pair_t cur;
  logic  done;

  assign out_valid = held;
  assign out_rec   = sel ? cur.rec1 : cur.rec0;
  // pair finishes when its last record is taken
  assign done  = held && !out_stall && (sel || cur.cnt != 2'd2);
  assign q_pop = q_not_empty && (!held || done);

  always_ff @(posedge clk) begin
    if (q_pop)
      cur <= q_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
      sel  <= 1'b0;
    end else if (q_pop) begin
      held <= 1'b1;
      sel  <= 1'b0;
    end else if (done) begin
      held <= 1'b0;
      sel  <= 1'b0;
    end else if (held && !out_stall) begin
      sel <= 1'b1;
    end
  end

endmodule
`default_nettype wire

[hdl/mqtt_packet_field_parser.sv]
// ----------------------------------------------------------------------------
// mqtt_packet_field_parser
// MQTT v3.1.1 fixed header, remaining length and body field parser.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while in_stall is low; a byte giving two records
//   is sent as two output transactions, absorbed by the pair queue (FIFO_DEPTH entries).
// Path: the records of a byte are written to the pair queue, then loaded into
//   the emitter's holding register, which drives out_valid and the record outputs.
// Reset: synchronous rst returns parser state, queue and output to empty and
//   max_string_len to 256. No clearing pass.
`default_nettype none
module mqtt_packet_field_parser #(
  parameter int MAX_SUB_ENTRIES = mpfp_pkg::MAX_SUB_ENTRIES_DEF,
  parameter int FIFO_DEPTH      = mpfp_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [16:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        segment_end,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       kind,
  output logic [27:0]      value,
  output logic [2:0]       string_slot,
  output logic [3:0]       entry_index,
  output logic [3:0]       ctrl_type,
  output logic             dup_flag,
  output logic [1:0]       qos_level,
  output logic             retain_flag,
  output logic [2:0]       verdict,
  output logic             packet_last
);
  import mpfp_pkg::*;

  pair_t pair;
  pair_t q_data;
  rec_t  rec;
  logic  accept, q_full, q_not_empty, q_pop;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  mpfp_parser #(.MAX_SUB_ENTRIES(MAX_SUB_ENTRIES)) u_parser (
    .clk, .rst, .cfg_write, .cfg_data, .accept, .data_byte, .segment_end, .pair
  );

  mpfp_queue #(.DEPTH(FIFO_DEPTH)) u_queue (
    .clk, .rst,
    .push      (accept && pair.cnt != 2'd0),
    .wdata     (pair),
    .full      (q_full),
    .not_empty (q_not_empty),
    .pop       (q_pop),
    .rdata     (q_data)
  );

  mpfp_emitter u_emitter (
    .clk, .rst, .q_not_empty, .q_data, .q_pop, .out_valid, .out_stall,
    .out_rec (rec)
  );

  assign kind        = rec.kind;
  assign value       = rec.value;
  assign string_slot = rec.string_slot;
  assign entry_index = rec.entry_index;
  assign ctrl_type   = rec.ctrl_type;
  assign dup_flag    = rec.dup_flag;
  assign qos_level   = rec.qos_level;
  assign retain_flag = rec.retain_flag;
  assign verdict     = rec.verdict;
  assign packet_last = rec.packet_last;

endmodule
`default_nettype wire

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb: MQTT packet field parser testbench
// Feeds segments byte by byte: a directed set of corner cases, then
// random segments, mostly well-formed packets with some damage. Both sides
// idle at random. A scoreboard predicts the field records of each byte
// and checks every record the block delivers, field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb;
  import mpfp_pkg::*;

  typedef enum int {
    PS_HDR, PS_LEN, PS_CLOSED, PS_SKIP, PS_STR_HI, PS_STR_LO, PS_STR_BODY,
    PS_VERSION, PS_FLAGS, PS_KA_HI, PS_KA_LO, PS_PID_HI, PS_PID_LO,
    PS_PAYLOAD, PS_SUBQOS
  } parse_phase_e;

  localparam int SUB_ENTRIES = 10;
  localparam int CYCLE_LIMIT = 400000;

  class parse_scoreboard;
    rec_t         records_due[$];
    int           mismatches;
    int           records_seen;
    logic [16:0]  str_cap;
    parse_phase_e phase;
    logic [7:0]   hdr;
    logic [27:0]  remaining;
    logic [2:0]   len_bytes;
    logic [7:0]   conn_flags;
    logic [15:0]  str_left;
    logic [2:0]   slot;
    logic [3:0]   entry_cnt;
    logic [7:0]   hold;
    logic [2:0]   pending_v;
    int           n_out;

    function new();
      str_cap = MAX_STRING_LEN_RST;
      clear_packet();
    endfunction

    function void clear_packet();
      phase = PS_HDR; hdr = '0; remaining = '0; len_bytes = '0; conn_flags = '0;
      str_left = '0; slot = '0; entry_cnt = '0; hold = '0; pending_v = V_OK;
    endfunction

    function void emit(logic [3:0] k, logic [27:0] v, logic [2:0] s, logic [3:0] e,
                       logic [2:0] verd);
      rec_t r;
      if (n_out >= 2) return;
      r.kind = k; r.value = v; r.string_slot = s; r.entry_index = e;
      r.ctrl_type = hdr[7:4]; r.dup_flag = hdr[3]; r.qos_level = hdr[2:1];
      r.retain_flag = hdr[0]; r.verdict = verd; r.packet_last = (k == K_VERDICT);
      records_due.push_back(r);
      n_out++;
    endfunction

    function void close_packet(logic [2:0] verd);
      emit(K_VERDICT, 28'd0, 3'd0, 4'd0, verd);
      phase = PS_CLOSED;
    endfunction

    function void start_string(logic [2:0] s);
      slot = s; phase = PS_STR_HI;
    endfunction

    function void skip_body(logic [2:0] verd);
      pending_v = verd; phase = PS_SKIP;
    endfunction

    function void begin_entry();
      if (entry_cnt < SUB_ENTRIES) start_string(S_SUBTOPIC);
      else skip_body(V_OK);
    endfunction

    function void after_password();
      if (conn_flags[6]) start_string(S_PASSWORD);
      else skip_body(V_OK);
    endfunction

    function void after_will();
      if (conn_flags[7]) start_string(S_USER);
      else after_password();
    endfunction

    function void after_string();
      case (slot)
        S_PROTONAME: phase = PS_VERSION;
        S_CLIENTID: begin
          if (conn_flags[2]) start_string(S_WILLTOPIC);
          else after_will();
        end
        S_WILLTOPIC: start_string(S_WILLMSG);
        S_WILLMSG:   after_will();
        S_USER:      after_password();
        S_PASSWORD:  skip_body(V_OK);
        S_PUBTOPIC:  phase = (hdr[2:1] != 2'd0) ? PS_PID_HI : PS_PAYLOAD;
        default:     phase = PS_SUBQOS;
      endcase
    endfunction

    function void start_body();
      case (hdr[7:4])
        T_CONNECT:   start_string(S_PROTONAME);
        T_PUBLISH:   start_string(S_PUBTOPIC);
        T_SUBSCRIBE: begin
          entry_cnt = '0; phase = PS_PID_HI;
        end
        T_CONNACK, T_UNSUBACK, T_PINGREQ, T_PINGRESP, T_DISCONN: skip_body(V_OK);
        default: skip_body(V_UNKNOWN);
      endcase
    endfunction

    function logic [2:0] end_verdict();
      case (phase)
        PS_STR_HI, PS_STR_LO, PS_STR_BODY: return (slot == S_SUBTOPIC) ? V_OK : V_MALFORMED;
        PS_VERSION, PS_FLAGS, PS_KA_HI, PS_KA_LO, PS_PID_HI, PS_PID_LO: return V_MALFORMED;
        PS_PAYLOAD, PS_SUBQOS: return V_OK;
        default: return pending_v;
      endcase
    endfunction

    function void body_byte(logic [7:0] b);
      logic [3:0]  e;
      logic [16:0] len;
      e = (slot == S_SUBTOPIC) ? entry_cnt : 4'd0;
      case (phase)
        PS_STR_HI: begin
          hold = b; phase = PS_STR_LO;
        end
        PS_STR_LO: begin
          len = {1'b0, hold, b};
          emit(K_STRLEN, 28'(len), slot, e, V_OK);
          if (len >= str_cap || 28'(len) > remaining)
            skip_body(slot == S_SUBTOPIC ? V_OK : V_MALFORMED);
          else if (len == 17'd0) after_string();
          else begin
            str_left = len[15:0]; phase = PS_STR_BODY;
          end
        end
        PS_STR_BODY: begin
          emit(K_STRBYTE, 28'(b), slot, e, V_OK);
          str_left = str_left - 16'd1;
          if (str_left == 16'd0) after_string();
        end
        PS_VERSION: begin
          emit(K_VERSION, 28'(b), 3'd0, 4'd0, V_OK); phase = PS_FLAGS;
        end
        PS_FLAGS: begin
          conn_flags = b; emit(K_CONNFLAGS, 28'(b), 3'd0, 4'd0, V_OK); phase = PS_KA_HI;
        end
        PS_KA_HI: begin
          hold = b; phase = PS_KA_LO;
        end
        PS_PID_HI: begin
          hold = b; phase = PS_PID_LO;
        end
        PS_KA_LO: begin
          emit(K_KEEPALIVE, 28'({hold, b}), 3'd0, 4'd0, V_OK); start_string(S_CLIENTID);
        end
        PS_PID_LO: begin
          emit(K_PACKETID, 28'({hold, b}), 3'd0, 4'd0, V_OK);
          if (hdr[7:4] == T_PUBLISH) phase = PS_PAYLOAD;
          else begin_entry();
        end
        PS_PAYLOAD: emit(K_PAYLOAD, 28'(b), 3'd0, 4'd0, V_OK);
        PS_SUBQOS: begin
          emit(K_SUBQOS, 28'(b), 3'd0, entry_cnt, V_OK);
          entry_cnt = entry_cnt + 4'd1;
          begin_entry();
        end
        default: ;
      endcase
    endfunction

    // predict the records caused by one accepted byte
    function void note_byte(logic [7:0] b, logic seg);
      logic [31:0] part;
      n_out = 0;
      if (phase == PS_HDR) begin
        hdr = b;
        emit(K_HEADER, 28'(b), 3'd0, 4'd0, V_OK);
        if (seg) close_packet(V_SHORT);
        else begin
          phase = PS_LEN; remaining = '0; len_bytes = '0;
        end
      end else if (phase == PS_LEN) begin
        part = 32'(b[6:0]) << (7 * len_bytes[1:0]);
        remaining = remaining | part[27:0];
        len_bytes = len_bytes + 3'd1;
        if (b[7]) begin
          if (len_bytes >= 3'd4 || seg) close_packet(V_BADLEN);
        end else begin
          emit(K_REMLEN, remaining, 3'd0, 4'd0, V_OK);
          start_body();
          if (remaining == 28'd0) close_packet(end_verdict());
          else if (seg) close_packet(V_TRUNC);
        end
      end else if (phase != PS_CLOSED) begin
        remaining = remaining - 28'd1;
        body_byte(b);
        if (remaining == 28'd0) close_packet(end_verdict());
        else if (seg) close_packet(V_TRUNC);
      end
      if (seg) clear_packet();
    endfunction

    function void report_mismatch(string what, logic [27:0] got, logic [27:0] want);
      $display("MISMATCH record %0d: %s got 0x%0h expected 0x%0h", records_seen, what,
               got, want);
      mismatches++;
    endfunction

    function void check_record(rec_t got);
      rec_t want;
      if (records_due.size() == 0) begin
        $display("MISMATCH record %0d: unexpected record kind %0d", records_seen, got.kind);
        mismatches++;
        records_seen++;
        return;
      end
      want = records_due.pop_front();
      if (got.kind !== want.kind)
        report_mismatch("kind", 28'(got.kind), 28'(want.kind));
      if (got.value !== want.value)
        report_mismatch("value", got.value, want.value);
      if (got.string_slot !== want.string_slot)
        report_mismatch("string_slot", 28'(got.string_slot), 28'(want.string_slot));
      if (got.entry_index !== want.entry_index)
        report_mismatch("entry_index", 28'(got.entry_index), 28'(want.entry_index));
      if (got.ctrl_type !== want.ctrl_type)
        report_mismatch("ctrl_type", 28'(got.ctrl_type), 28'(want.ctrl_type));
      if (got.dup_flag !== want.dup_flag)
        report_mismatch("dup_flag", 28'(got.dup_flag), 28'(want.dup_flag));
      if (got.qos_level !== want.qos_level)
        report_mismatch("qos_level", 28'(got.qos_level), 28'(want.qos_level));
      if (got.retain_flag !== want.retain_flag)
        report_mismatch("retain_flag", 28'(got.retain_flag), 28'(want.retain_flag));
      if (got.verdict !== want.verdict)
        report_mismatch("verdict", 28'(got.verdict), 28'(want.verdict));
      if (got.packet_last !== want.packet_last)
        report_mismatch("packet_last", 28'(got.packet_last), 28'(want.packet_last));
      records_seen++;
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_write = 0;
  logic [16:0] cfg_data = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [7:0]  data_byte = 0;
  logic        segment_end = 0;
  logic        out_valid;
  logic        out_stall = 0;
  rec_t        got_rec;

  parse_scoreboard sb = new();
  int cycles = 0;
  int burst_left = 0;
  int bytes_sent = 0;
  int segments_sent = 0;
  int stall_mode = 0;
  int stall_left = 0;

  mqtt_packet_field_parser i_dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .data_byte(data_byte),
    .segment_end(segment_end), .out_valid(out_valid), .out_stall(out_stall),
    .kind(got_rec.kind), .value(got_rec.value), .string_slot(got_rec.string_slot),
    .entry_index(got_rec.entry_index), .ctrl_type(got_rec.ctrl_type),
    .dup_flag(got_rec.dup_flag), .qos_level(got_rec.qos_level),
    .retain_flag(got_rec.retain_flag), .verdict(got_rec.verdict),
    .packet_last(got_rec.packet_last)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver stall pattern: free runs, random stalls, alternating, long holds
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(10, 60);
      out_stall  <= 1'b0;
    end else begin
      stall_left <= stall_left - 1;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 9) < 3);
        2: out_stall <= ~out_stall;
        default: out_stall <= ($urandom_range(0, 9) < 8);
      endcase
    end
  end

  // outputs are stable between edges; a transaction completes at the next rising edge
  always @(negedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_record(got_rec);
  end

  task automatic sender_idle(int n);
    repeat (n) begin
      @(posedge clk);
      in_valid <= 1'b0;
    end
  endtask

  task automatic send_byte(logic [7:0] b, logic seg);
    if (burst_left == 0) begin
      if ($urandom_range(0, 2) != 0) sender_idle($urandom_range(1, 6));
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    @(posedge clk);
    in_valid    <= 1'b1;
    data_byte   <= b;
    segment_end <= seg;
    do @(negedge clk); while (in_stall);
    sb.note_byte(b, seg);
    bytes_sent++;
  endtask

  task automatic send_segment(ref logic [7:0] seg_q[$]);
    for (int i = 0; i < seg_q.size(); i++) send_byte(seg_q[i], i == seg_q.size() - 1);
    segments_sent++;
  endtask

  task automatic wait_idle();
    sender_idle(1);
    while (sb.records_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_cap(logic [16:0] v);
    wait_idle();
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.str_cap = v;
  endtask

  function automatic int pick_strlen(logic [16:0] cap);
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 16'hFFFF;
    if (r == 1) return (cap > 65535) ? 300 : int'(cap);
    if (r < 4) return 0;
    return $urandom_range(1, 6);
  endfunction

  function automatic void put_string(ref logic [7:0] q[$], input int len);
    q.push_back(len[15:8]);
    q.push_back(len[7:0]);
    for (int i = 0; i < len && i < 8; i++) q.push_back(8'($urandom_range(0, 255)));
  endfunction

  // random packet: mostly well formed, sometimes damaged
  function automatic void build_segment(ref logic [7:0] q[$], input logic [16:0] cap);
    logic [7:0] body[$];
    logic [7:0] h;
    logic [7:0] fl;
    int         sel, rl, n;
    sel = $urandom_range(0, 9);
    h = 8'($urandom_range(0, 255));
    if (sel < 3) begin
      h[7:4] = T_CONNECT;
      fl = 8'($urandom_range(0, 255));
      put_string(body, ($urandom_range(0, 3) == 0) ? pick_strlen(cap) : 4);
      body.push_back(8'($urandom_range(0, 255)));
      body.push_back(fl);
      body.push_back(8'($urandom_range(0, 255)));
      body.push_back(8'($urandom_range(0, 255)));
      put_string(body, pick_strlen(cap));
      if (fl[2]) begin
        put_string(body, pick_strlen(cap));
        put_string(body, pick_strlen(cap));
      end
      if (fl[7]) put_string(body, pick_strlen(cap));
      if (fl[6]) put_string(body, pick_strlen(cap));
    end else if (sel < 6) begin
      h[7:4] = T_PUBLISH;
      put_string(body, pick_strlen(cap));
      if (h[2:1] != 2'd0) begin
        body.push_back(8'($urandom_range(0, 255)));
        body.push_back(8'($urandom_range(0, 255)));
      end
      n = $urandom_range(0, 8);
      repeat (n) body.push_back(8'($urandom_range(0, 255)));
    end else if (sel < 8) begin
      h[7:4] = T_SUBSCRIBE;
      body.push_back(8'($urandom_range(0, 255)));
      body.push_back(8'($urandom_range(0, 255)));
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 3);
      repeat (n) begin
        put_string(body, ($urandom_range(0, 5) == 0) ? pick_strlen(cap) : $urandom_range(0, 3));
        body.push_back(8'($urandom_range(0, 255)));
      end
    end else begin
      n = $urandom_range(0, 4);
      repeat (n) body.push_back(8'($urandom_range(0, 255)));
    end
    rl = body.size();
    case ($urandom_range(0, 9))
      0: rl = rl + $urandom_range(1, 5);
      1: rl = (rl > 0) ? $urandom_range(0, rl - 1) : 0;
      2: rl = $urandom_range(128, 20000);
      default: ;
    endcase
    q.push_back(h);
    if ($urandom_range(0, 24) == 0) begin
      // malformed length field
      repeat ($urandom_range(1, 5)) q.push_back(8'(8'h80 | $urandom_range(0, 127)));
    end else begin
      do begin
        q.push_back(8'(((rl > 127) ? 8'h80 : 8'h00) | (rl & 127)));
        rl = rl >> 7;
      end while (rl != 0);
    end
    foreach (body[i]) q.push_back(body[i]);
    case ($urandom_range(0, 7))
      0: if (q.size() > 1) q = q[0:$urandom_range(0, q.size() - 2)];
      1: repeat ($urandom_range(1, 4)) q.push_back(8'($urandom_range(0, 255)));
      default: ;
    endcase
  endfunction

  task automatic run_directed();
    logic [7:0] q[$];
    q = '{8'hFF};                                    send_segment(q); // header only
    q = '{8'h00};                                    send_segment(q);
    q = '{8'hC0, 8'h00};                             send_segment(q); // pingreq
    q = '{8'hF0, 8'h00};                             send_segment(q); // unknown type
    q = '{8'h30, 8'h80};                             send_segment(q); // ends in length
    q = '{8'h30, 8'h80, 8'h80, 8'h80, 8'h80, 8'h00}; send_segment(q); // 4th cont bit
    q = '{8'h3F, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h00}; send_segment(q); // max remlen
    q = '{8'h10, 8'h0C, 8'h00, 8'h01, 8'h4D, 8'h04, 8'hC6, 8'h00, 8'h3C,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};  send_segment(q);
    q = '{8'h32, 8'h06, 8'h00, 8'h01, 8'h61, 8'h12, 8'h34, 8'hAA}; send_segment(q);
    q = '{8'h82, 8'h06, 8'h00, 8'h07, 8'h00, 8'h01, 8'h62, 8'h01}; send_segment(q);
    q = '{8'h82, 8'h04, 8'h00, 8'h07, 8'hFF, 8'hFF};  send_segment(q); // bad sub topic
    q = '{8'h10, 8'h02, 8'h00};                      send_segment(q); // cut string
  endtask

  initial begin
    logic [16:0] caps[5] = '{17'd256, 17'd1, 17'd65536, 17'd4, 17'd300};
    logic [7:0]  q[$];
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    foreach (caps[c]) begin
      write_cap(caps[c]);
      while (bytes_sent < 80 + (c + 1) * 150) begin
        q.delete();
        build_segment(q, caps[c]);
        send_segment(q);
      end
    end
    wait_idle();
    repeat (20) @(posedge clk);
    $display("Sent %0d bytes in %0d segments over 5 string limits; %0d records checked",
             bytes_sent, segments_sent, sb.records_seen);
    if (sb.mismatches == 0 && sb.records_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches, %0d records missing", sb.mismatches, sb.records_due.size());
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/mpfp_pkg.sv
hdl/mpfp_parser.sv
hdl/mpfp_queue.sv
hdl/mpfp_emitter.sv
hdl/mqtt_packet_field_parser.sv
tb/sv/tb.sv
